@@ sv/humidity_fan_level_hysteresis_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the humidity fan level block
// Shared forms for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_FAN_LEVEL_HYSTERESIS_ASSERT_SVH
`define HUMIDITY_FAN_LEVEL_HYSTERESIS_ASSERT_SVH

// Checked on every rising edge, ignored while reset is asserted.
`define HFL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define HFL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/hfl_pkg.sv @@
// ----------------------------------------------------------------------------
// hfl_pkg
// Types, codes and reset values shared by the humidity fan level block.
// ----------------------------------------------------------------------------
package hfl_pkg;

    localparam int THR_W    = 10;
    localparam int MARGIN_W = 7;
    localparam int LIMIT_W  = 16;
    localparam int TIME_W   = 32;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    typedef enum logic [1:0] {
        LVL_STOP   = 2'd0,
        LVL_SLOW   = 2'd1,
        LVL_NORMAL = 2'd2,
        LVL_FAST   = 2'd3
    } level_t;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_CHECK  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        REG_SLOW_THR   = 3'd0,
        REG_NORMAL_THR = 3'd1,
        REG_FAST_THR   = 3'd2,
        REG_DOWN_MARGIN = 3'd3,
        REG_SILENCE_LIMIT = 3'd4
    } reg_idx_t;

    localparam logic [THR_W-1:0]    RST_SLOW_THR   = 10'd300;
    localparam logic [THR_W-1:0]    RST_NORMAL_THR = 10'd350;
    localparam logic [THR_W-1:0]    RST_FAST_THR   = 10'd400;
    localparam logic [MARGIN_W-1:0] RST_DOWN_MARGIN = 7'd5;
    localparam logic [LIMIT_W-1:0]  RST_SILENCE_LIMIT = 16'd5000;

    typedef struct packed {
        logic [THR_W-1:0]    slow_threshold;
        logic [THR_W-1:0]    normal_threshold;
        logic [THR_W-1:0]    fast_threshold;
        logic [MARGIN_W-1:0] down_margin;
        logic [LIMIT_W-1:0]  silence_limit_ms;
    } cfg_t;

    typedef struct packed {
        logic              cmd;
        logic [THR_W-1:0]  humidity_tenths;
        logic [TIME_W-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic [1:0] fan_speed;
        logic       by_timeout;
    } result_t;

endpackage

@@ sv/hfl_cfg.sv @@
// ----------------------------------------------------------------------------
// hfl_cfg
// APB register file holding thresholds, hysteresis margin and silence limit.
// ----------------------------------------------------------------------------
module hfl_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hfl_pkg::APB_AW-1:0]  paddr,
    input  logic [hfl_pkg::APB_DW-1:0]  pwdata,
    output logic [hfl_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output hfl_pkg::cfg_t               cfg
);

    localparam int APB_AW_HI = hfl_pkg::APB_AW - 1;

    hfl_pkg::cfg_t    cfg_reg;
    hfl_pkg::cfg_t    cfg_next;
    hfl_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = hfl_pkg::reg_idx_t'(paddr[APB_AW_HI:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                hfl_pkg::REG_SLOW_THR:
                    cfg_next.slow_threshold = pwdata[hfl_pkg::THR_W-1:0];
                hfl_pkg::REG_NORMAL_THR:
                    cfg_next.normal_threshold = pwdata[hfl_pkg::THR_W-1:0];
                hfl_pkg::REG_FAST_THR:
                    cfg_next.fast_threshold = pwdata[hfl_pkg::THR_W-1:0];
                hfl_pkg::REG_DOWN_MARGIN:
                    cfg_next.down_margin = pwdata[hfl_pkg::MARGIN_W-1:0];
                hfl_pkg::REG_SILENCE_LIMIT:
                    cfg_next.silence_limit_ms = pwdata[hfl_pkg::LIMIT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            hfl_pkg::REG_SLOW_THR:
                prdata = hfl_pkg::APB_DW'(cfg_reg.slow_threshold);
            hfl_pkg::REG_NORMAL_THR:
                prdata = hfl_pkg::APB_DW'(cfg_reg.normal_threshold);
            hfl_pkg::REG_FAST_THR:
                prdata = hfl_pkg::APB_DW'(cfg_reg.fast_threshold);
            hfl_pkg::REG_DOWN_MARGIN:
                prdata = hfl_pkg::APB_DW'(cfg_reg.down_margin);
            hfl_pkg::REG_SILENCE_LIMIT:
                prdata = hfl_pkg::APB_DW'(cfg_reg.silence_limit_ms);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_threshold   <= hfl_pkg::RST_SLOW_THR;
            cfg_reg.normal_threshold <= hfl_pkg::RST_NORMAL_THR;
            cfg_reg.fast_threshold   <= hfl_pkg::RST_FAST_THR;
            cfg_reg.down_margin      <= hfl_pkg::RST_DOWN_MARGIN;
            cfg_reg.silence_limit_ms <= hfl_pkg::RST_SILENCE_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ sv/hfl_level_unit.sv @@
// ----------------------------------------------------------------------------
// hfl_level_unit
// Level state, last sample time and the per-transaction level decision.
// ----------------------------------------------------------------------------
module hfl_level_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  hfl_pkg::sample_t  item,
    input  hfl_pkg::cfg_t     cfg,
    output logic              emit,
    output hfl_pkg::result_t  res
);

    hfl_pkg::level_t                level_reg;
    hfl_pkg::level_t                level_next;
    logic                           known_reg;
    logic                           known_next;
    logic [hfl_pkg::TIME_W-1:0]     last_reg;
    logic [hfl_pkg::TIME_W-1:0]     last_next;

    hfl_pkg::level_t                classed;
    hfl_pkg::level_t                raised;
    hfl_pkg::level_t                target;
    logic                           ge_slow;
    logic                           ge_normal;
    logic                           ge_fast;
    logic                           dn_slow;
    logic                           dn_normal;
    logic                           dn_fast;
    logic [hfl_pkg::THR_W:0]        h_up;
    logic [hfl_pkg::TIME_W-1:0]     elapsed;
    logic                           timed_out;
    logic                           is_sample;

    assign is_sample = (item.cmd == hfl_pkg::CMD_SAMPLE);

    assign ge_slow   = item.humidity_tenths >= cfg.slow_threshold;
    assign ge_normal = item.humidity_tenths >= cfg.normal_threshold;
    assign ge_fast   = item.humidity_tenths >= cfg.fast_threshold;

    // h < thr - margin, rearranged as h + margin < thr so it never goes negative.
    assign h_up      = {1'b0, item.humidity_tenths}
                     + (hfl_pkg::THR_W + 1)'(cfg.down_margin);
    assign dn_slow   = h_up < {1'b0, cfg.slow_threshold};
    assign dn_normal = h_up < {1'b0, cfg.normal_threshold};
    assign dn_fast   = h_up < {1'b0, cfg.fast_threshold};

    assign elapsed   = item.now_ms - last_reg;
    assign timed_out = elapsed > hfl_pkg::TIME_W'(cfg.silence_limit_ms);

    always_comb
    begin
        if (ge_fast)
            classed = hfl_pkg::LVL_FAST;
        else if (ge_normal)
            classed = hfl_pkg::LVL_NORMAL;
        else if (ge_slow)
            classed = hfl_pkg::LVL_SLOW;
        else
            classed = hfl_pkg::LVL_STOP;
    end

    // Raise at once, step down through every band it clears; unknown level: classify.
    always_comb
    begin
        raised = level_reg;
        if (ge_fast)
            raised = hfl_pkg::LVL_FAST;
        else if (ge_normal && level_reg < hfl_pkg::LVL_NORMAL)
            raised = hfl_pkg::LVL_NORMAL;
        else if (ge_slow && level_reg < hfl_pkg::LVL_SLOW)
            raised = hfl_pkg::LVL_SLOW;

        target = raised;
        if (target == hfl_pkg::LVL_FAST && dn_fast)
            target = hfl_pkg::LVL_NORMAL;
        if (target == hfl_pkg::LVL_NORMAL && dn_normal)
            target = hfl_pkg::LVL_SLOW;
        if (target == hfl_pkg::LVL_SLOW && dn_slow)
            target = hfl_pkg::LVL_STOP;
        if (!known_reg)
            target = classed;
    end

    always_comb
    begin
        level_next = level_reg;
        known_next = known_reg;
        last_next  = last_reg;
        if (is_sample)
        begin
            emit           = !known_reg || (target != level_reg);
            res.fan_speed  = target;
            res.by_timeout = 1'b0;
        end
        else
        begin
            emit           = timed_out && (!known_reg || level_reg != hfl_pkg::LVL_STOP);
            res.fan_speed  = hfl_pkg::LVL_STOP;
            res.by_timeout = 1'b1;
        end
        if (go)
        begin
            if (is_sample)
            begin
                level_next = target;
                known_next = 1'b1;
                last_next  = item.now_ms;
            end
            else if (emit)
            begin
                level_next = hfl_pkg::LVL_STOP;
                known_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= hfl_pkg::LVL_STOP;
            known_reg <= 1'b0;
            last_reg  <= '0;
        end
        else
        begin
            level_reg <= level_next;
            known_reg <= known_next;
            last_reg  <= last_next;
        end
    end

endmodule

@@ sv/humidity_fan_level_hysteresis.sv @@
// ----------------------------------------------------------------------------
// humidity_fan_level_hysteresis
// Fan speed level from humidity samples with hysteresis and silence failsafe.
// ----------------------------------------------------------------------------
// Usage:
//   The sample channel (sample_valid, sample_stall, sample) carries humidity
//   samples and timeout checks, each with a millisecond timestamp. The result
//   channel (result_valid, result_stall, result) carries a new speed level,
//   produced when the level changes or no level is known yet. A transaction
//   moves at a rising edge with valid high and stall low.
//   The sample lands in an input register, the level decision runs against
//   the level register, and the result is held in an output register. One
//   transaction is taken every cycle while the result is not stalled; the
//   level register update in the decision cycle sets that rate.
//   While a pending result is stalled, an empty input register still takes
//   one transaction; once it holds one, sample_stall stays high until the
//   result drains.
//   Reset clears the level to STOP with no level known, the last sample time
//   to zero and the registers to their defaults. Registers are to be written
//   through the APB port while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module humidity_fan_level_hysteresis (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_stall,
    input  hfl_pkg::sample_t            sample,
    output logic                        result_valid,
    input  logic                        result_stall,
    output hfl_pkg::result_t            result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hfl_pkg::APB_AW-1:0]  paddr,
    input  logic [hfl_pkg::APB_DW-1:0]  pwdata,
    output logic [hfl_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    hfl_pkg::cfg_t     cfg;
    hfl_pkg::sample_t  in_data_reg;
    hfl_pkg::sample_t  in_data_next;
    logic              in_vld_reg;
    logic              in_vld_next;
    hfl_pkg::result_t  out_data_reg;
    hfl_pkg::result_t  out_data_next;
    logic              out_vld_reg;
    logic              out_vld_next;
    logic              advance;
    logic              emit;
    hfl_pkg::result_t  res;

    hfl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hfl_level_unit u_level (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (advance),
        .item  (in_data_reg),
        .cfg   (cfg),
        .emit  (emit),
        .res   (res)
    );

    // The held transaction moves on unless the output register is full and stalled.
    assign advance      = in_vld_reg && !(out_vld_reg && result_stall);
    assign sample_stall = in_vld_reg && !advance;
    assign result_valid = out_vld_reg;
    assign result       = out_data_reg;

    always_comb
    begin
        in_vld_next  = in_vld_reg;
        in_data_next = in_data_reg;
        if (!sample_stall)
        begin
            in_vld_next = sample_valid;
            if (sample_valid)
                in_data_next = sample;
        end
    end

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        if (advance && emit)
        begin
            out_vld_next  = 1'b1;
            out_data_next = res;
        end
        else if (!result_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ sv/hfl_checker.sv @@
// ----------------------------------------------------------------------------
// hfl_checker
// Port-level checks on the humidity fan level block, bound to the top level.
// ----------------------------------------------------------------------------
`include "humidity_fan_level_hysteresis_assert.svh"

module hfl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              sample_valid,
    input logic              sample_stall,
    input logic              result_valid,
    input logic              result_stall,
    input hfl_pkg::result_t  result,
    input logic              pready
);

    // A stalled result stays offered and unchanged.
    `HFL_ASSERT(a_result_hold,
        result_valid && result_stall |=> result_valid && $stable(result),
        "stalled result changed")

    // The failsafe only ever drives the fan to STOP.
    `HFL_ASSERT(a_timeout_stop,
        result_valid && result.by_timeout |-> result.fan_speed == hfl_pkg::LVL_STOP,
        "timeout result is not STOP")

    // A fresh result needs a transaction taken earlier into the input register.
    `HFL_ASSERT(a_result_cause,
        $rose(result_valid) |-> $past(sample_valid && !sample_stall, 2),
        "result without a sample")

    `HFL_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

endmodule

bind humidity_fan_level_hysteresis hfl_checker u_hfl_checker (.*);
